### sv/cpt_pkg.sv
package cpt_pkg;

    // Default widths of the temperature and power words.
    localparam int DEF_TEMP_WIDTH  = 16;
    localparam int DEF_POWER_WIDTH = 24;

    // Fixed formats: gain in units of 2^-16, fraction in Q0.16 with room for 1.0.
    localparam int GAIN_WIDTH      = 16;
    localparam int FRAC_WIDTH      = 17;
    localparam int FRAC_SHIFT      = 6;
    localparam int MODE_WIDTH      = 3;
    localparam int REG_INDEX_WIDTH = 3;

    localparam logic [FRAC_WIDTH-1:0] ONE_Q16 = FRAC_WIDTH'(65536);

    // Register reset values.
    localparam int RST_MODE         = 1;
    localparam int RST_OFF_TEMP     = 18762;
    localparam int RST_ON_TEMP      = 19082;
    localparam int RST_TARGET_TEMP  = 18762;
    localparam int RST_PROP_GAIN    = 13107;
    localparam int RST_MIN_FRACTION = 13107;
    localparam int RST_FULL_POWER   = 7500;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_MODE         = 3'd0,
        REG_OFF_TEMP     = 3'd1,
        REG_ON_TEMP      = 3'd2,
        REG_TARGET_TEMP  = 3'd3,
        REG_PROP_GAIN    = 3'd4,
        REG_MIN_FRACTION = 3'd5,
        REG_FULL_POWER   = 3'd6
    } reg_index_t;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_ALWAYS_ON = 3'd1,
        MODE_HYST_CONT = 3'd2,
        MODE_HYST_HOT  = 3'd3,
        MODE_PROP_CONT = 3'd4,
        MODE_PROP_HOT  = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FRAC,
        ST_SAT_FRAC,
        ST_MUL_POWER,
        ST_WRITE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mul_frac;
        logic sat_frac;
        logic mul_power;
        logic load;
    } dp_cmd_t;

endpackage

### sv/cooling_power_thermostat_unit.sv
// Cooling-unit thermostat. Each word on the input channel carries the container
// and hot-spot temperatures (unsigned Q10.6 kelvin) and yields exactly one output
// word with the new cooling power in watts and a flag that is set when the power
// is nonzero. An accepted word is walked by the controller through two products
// and a saturation step on one shared multiplier and is then loaded into the
// output register once that register is free; a new word is taken in the cycle
// the previous result is loaded, so the block does not take a new word before
// the last one is loaded. Configuration registers are written through cfg_write,
// cfg_index and cfg_data and must only be changed while no word is in flight;
// indexes beyond the full-power register are ignored.
module cooling_power_thermostat_unit #(
    parameter int TEMP_WIDTH  = cpt_pkg::DEF_TEMP_WIDTH,
    parameter int POWER_WIDTH = cpt_pkg::DEF_POWER_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cpt_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((POWER_WIDTH > TEMP_WIDTH) ?
                   ((POWER_WIDTH > cpt_pkg::FRAC_WIDTH) ? POWER_WIDTH : cpt_pkg::FRAC_WIDTH) :
                   ((TEMP_WIDTH > cpt_pkg::FRAC_WIDTH) ? TEMP_WIDTH : cpt_pkg::FRAC_WIDTH))-1:0]
                                                cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [TEMP_WIDTH-1:0]               container_temp,
    input  logic [TEMP_WIDTH-1:0]               hotspot_temp,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [POWER_WIDTH-1:0]              cooling_power,
    output logic                                cooling_active
);
    import cpt_pkg::*;

    localparam int CFG_WIDTH = $bits(cfg_data);

    dp_cmd_t cmd;

    cpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cpt_datapath #(
        .TEMP_WIDTH  (TEMP_WIDTH),
        .POWER_WIDTH (POWER_WIDTH),
        .CFG_WIDTH   (CFG_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .container_temp (container_temp),
        .hotspot_temp   (hotspot_temp),
        .cmd            (cmd),
        .cooling_power  (cooling_power),
        .cooling_active (cooling_active)
    );

endmodule

### sv/cpt_ctrl.sv
module cpt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output cpt_pkg::dp_cmd_t cmd
);
    import cpt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;
    logic   can_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        // The output register may be overwritten when empty or being taken.
        can_load   = !out_valid_reg || !out_stall;
        can_accept = (state_reg == ST_IDLE) || ((state_reg == ST_WRITE) && can_load);
        state_next = state_reg;
        cmd        = '0;
        cmd.capture = in_valid && can_accept;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_FRAC;
                end
            end
            ST_MUL_FRAC:
            begin
                cmd.mul_frac = 1'b1;
                state_next   = ST_SAT_FRAC;
            end
            ST_SAT_FRAC:
            begin
                cmd.sat_frac = 1'b1;
                state_next   = ST_MUL_POWER;
            end
            ST_MUL_POWER:
            begin
                cmd.mul_power = 1'b1;
                state_next    = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    cmd.load   = 1'b1;
                    state_next = in_valid ? ST_MUL_FRAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = !can_accept;
    assign out_valid = out_valid_reg;

endmodule

### sv/cpt_datapath.sv
module cpt_datapath #(
    parameter int TEMP_WIDTH  = cpt_pkg::DEF_TEMP_WIDTH,
    parameter int POWER_WIDTH = cpt_pkg::DEF_POWER_WIDTH,
    parameter int CFG_WIDTH   = cpt_pkg::DEF_POWER_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cpt_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                cfg_data,
    input  logic [TEMP_WIDTH-1:0]               container_temp,
    input  logic [TEMP_WIDTH-1:0]               hotspot_temp,
    input  cpt_pkg::dp_cmd_t                    cmd,
    output logic [POWER_WIDTH-1:0]              cooling_power,
    output logic                                cooling_active
);
    import cpt_pkg::*;

    localparam int MULT_A_WIDTH = (TEMP_WIDTH > POWER_WIDTH) ? TEMP_WIDTH : POWER_WIDTH;
    localparam int PROD_WIDTH   = MULT_A_WIDTH + FRAC_WIDTH;
    localparam int FRAC_FULL_W  = PROD_WIDTH - FRAC_SHIFT;

    // Configuration registers.
    logic [MODE_WIDTH-1:0]  mode_reg;
    logic [TEMP_WIDTH-1:0]  off_temp_reg;
    logic [TEMP_WIDTH-1:0]  on_temp_reg;
    logic [TEMP_WIDTH-1:0]  target_temp_reg;
    logic [GAIN_WIDTH-1:0]  prop_gain_reg;
    logic [FRAC_WIDTH-1:0]  min_fraction_reg;
    logic [POWER_WIDTH-1:0] full_power_reg;

    // Working registers.
    logic [TEMP_WIDTH-1:0]  temp_reg;
    logic [TEMP_WIDTH-1:0]  hot_reg;
    logic [TEMP_WIDTH-1:0]  err_reg;
    logic [PROD_WIDTH-1:0]  mult_reg;
    logic [FRAC_WIDTH-1:0]  frac_sat_reg;
    logic                   cut_reg;
    logic [POWER_WIDTH-1:0] held_power_reg;

    logic [TEMP_WIDTH-1:0]   err_src;
    logic [TEMP_WIDTH-1:0]   err_next;
    logic [MULT_A_WIDTH-1:0] mult_a;
    logic [FRAC_WIDTH-1:0]   mult_b;
    logic [FRAC_FULL_W-1:0]  frac_full;
    logic [POWER_WIDTH-1:0]  prop_power;
    logic [POWER_WIDTH-1:0]  power_next;
    logic                    off_cut;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_WIDTH'(RST_MODE);
            off_temp_reg     <= TEMP_WIDTH'(RST_OFF_TEMP);
            on_temp_reg      <= TEMP_WIDTH'(RST_ON_TEMP);
            target_temp_reg  <= TEMP_WIDTH'(RST_TARGET_TEMP);
            prop_gain_reg    <= GAIN_WIDTH'(RST_PROP_GAIN);
            min_fraction_reg <= FRAC_WIDTH'(RST_MIN_FRACTION);
            full_power_reg   <= POWER_WIDTH'(RST_FULL_POWER);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:         mode_reg         <= cfg_data[MODE_WIDTH-1:0];
                REG_OFF_TEMP:     off_temp_reg     <= cfg_data[TEMP_WIDTH-1:0];
                REG_ON_TEMP:      on_temp_reg      <= cfg_data[TEMP_WIDTH-1:0];
                REG_TARGET_TEMP:  target_temp_reg  <= cfg_data[TEMP_WIDTH-1:0];
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[GAIN_WIDTH-1:0];
                REG_MIN_FRACTION: min_fraction_reg <= cfg_data[FRAC_WIDTH-1:0];
                REG_FULL_POWER:   full_power_reg   <= cfg_data[POWER_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The held power is also the output word; it starts at the full power.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_power_reg <= POWER_WIDTH'(RST_FULL_POWER);
        end
        else if (cmd.load)
        begin
            held_power_reg <= power_next;
        end
    end

    always_comb
    begin
        err_src  = (mode_reg == MODE_PROP_HOT) ? hotspot_temp : container_temp;
        err_next = (err_src > target_temp_reg) ? (err_src - target_temp_reg) : '0;
        mult_a   = cmd.mul_power ? MULT_A_WIDTH'(full_power_reg) : MULT_A_WIDTH'(err_reg);
        mult_b   = cmd.mul_power ? frac_sat_reg : FRAC_WIDTH'(prop_gain_reg);
        frac_full  = mult_reg[PROD_WIDTH-1:FRAC_SHIFT];
        prop_power = mult_reg[16 +: POWER_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            temp_reg <= container_temp;
            hot_reg  <= hotspot_temp;
            err_reg  <= err_next;
        end
        if (cmd.mul_frac || cmd.mul_power)
        begin
            mult_reg <= PROD_WIDTH'(mult_a) * PROD_WIDTH'(mult_b);
        end
        if (cmd.sat_frac)
        begin
            // A fraction equal to the minimum still gives no cooling.
            cut_reg      <= frac_full <= FRAC_FULL_W'(min_fraction_reg);
            frac_sat_reg <= (frac_full > FRAC_FULL_W'(ONE_Q16)) ? ONE_Q16
                                                                : frac_full[FRAC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        off_cut    = temp_reg <= off_temp_reg;
        power_next = held_power_reg;
        unique case (mode_reg)
            MODE_ALWAYS_ON:
            begin
                // At the off threshold itself this mode still cools.
                power_next = (temp_reg < off_temp_reg) ? '0 : full_power_reg;
            end
            MODE_HYST_CONT:
            begin
                if (off_cut)
                begin
                    power_next = '0;
                end
                else if (temp_reg >= on_temp_reg)
                begin
                    power_next = full_power_reg;
                end
            end
            MODE_HYST_HOT:
            begin
                if (off_cut)
                begin
                    power_next = '0;
                end
                else if (hot_reg >= on_temp_reg)
                begin
                    power_next = full_power_reg;
                end
            end
            MODE_PROP_CONT, MODE_PROP_HOT:
            begin
                power_next = (off_cut || cut_reg) ? '0 : prop_power;
            end
            default:
            begin
                power_next = held_power_reg;
            end
        endcase
    end

    assign cooling_power  = held_power_reg;
    assign cooling_active = held_power_reg != '0;

endmodule
